@@ rtl/core/lcp_pkg.sv @@
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types and constants of the line command parser: keyword tables,
// character codes, status codes and the front-to-back command record.
// ----------------------------------------------------------------------------
package lcp_pkg;

  localparam int LINE_CAPACITY_DEF = 1024;
  localparam int PERIOD_BITS_DEF   = 16;
  localparam int OUT_PERIOD_W      = 16;

  localparam int KW_COUNT = 6;
  localparam int KW_SCALE  = 0;
  localparam int KW_PERIOD = 1;
  localparam int KW_STOP   = 2;
  localparam int KW_START  = 3;
  localparam int KW_LOG    = 4;
  localparam int KW_OFF    = 5;

  // keyword text, one byte per position, padded with zeros
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{8'h53, 8'h43, 8'h41, 8'h4C, 8'h45, 8'h3D, 8'h00, 8'h00},
    '{8'h50, 8'h45, 8'h52, 8'h49, 8'h4F, 8'h44, 8'h3D, 8'h00},
    '{8'h53, 8'h54, 8'h4F, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h54, 8'h41, 8'h52, 8'h54, 8'h00, 8'h00, 8'h00},
    '{8'h4C, 8'h4F, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4F, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd6, 4'd7, 4'd4, 4'd5, 4'd3, 4'd3};
  // keywords that must end the line exactly
  localparam logic [KW_COUNT-1:0] KW_EXACT = 6'b101100;

  localparam int SCALE_CHAR_POS = 6;
  localparam int NUMBER_POS     = 7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_F     = 8'h46;

  typedef enum logic [3:0] {
    ST_SCALE_SET  = 4'd0,
    ST_SCALE_REJ  = 4'd1,
    ST_PERIOD_SET = 4'd2,
    ST_PERIOD_REJ = 4'd3,
    ST_STOP       = 4'd4,
    ST_START      = 4'd5,
    ST_LOG        = 4'd6,
    ST_OFF        = 4'd7,
    ST_UNKNOWN    = 4'd8
  } status_t;

  typedef struct packed {
    status_t status;
    logic    celsius;
  } cmd_t;

  typedef enum logic [2:0] {
    NUM_SKIP   = 3'b001,
    NUM_DIGITS = 3'b010,
    NUM_DONE   = 3'b100
  } num_phase_t;

endpackage

@@ rtl/core/lcp_if.sv @@
// ----------------------------------------------------------------------------
// lcp_if
// Valid/ready channels of the line command parser: received bytes in,
// status reports out.
// ----------------------------------------------------------------------------
interface lcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lcp_status_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic        celsius_mode;
  logic [15:0] report_period;
  logic        reports_stopped;
  logic        shut_down;

  modport source (output valid, output status, output celsius_mode, output report_period,
                  output reports_stopped, output shut_down, input ready);
  modport sink (input valid, input status, input celsius_mode, input report_period,
                input reports_stopped, input shut_down, output ready);
endinterface

@@ rtl/core/lcp_front.sv @@
// ----------------------------------------------------------------------------
// lcp_front
// Byte front end: matches each line against the keywords as it streams in,
// parses the scale character and the period number, and on newline pushes
// one classified command into the queue.
// ----------------------------------------------------------------------------
module lcp_front #(
  parameter int LINE_CAPACITY = lcp_pkg::LINE_CAPACITY_DEF,
  parameter int PERIOD_BITS   = lcp_pkg::PERIOD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  lcp_byte_if.sink               in_if,
  input  logic                   q_full,
  output logic                   push,
  output lcp_pkg::cmd_t          push_cmd,
  output logic [PERIOD_BITS-1:0] push_period
);

  localparam int PW = $clog2(LINE_CAPACITY + 1);
  localparam int NW = PERIOD_BITS + 4;

  logic [PW-1:0]                   pos_r, pos_nxt;
  logic [lcp_pkg::KW_COUNT-1:0]    match_r, match_nxt;
  logic                            ended_r, ended_nxt;
  logic [7:0]                      scale_char_r, scale_char_nxt;
  lcp_pkg::num_phase_t             phase_r, phase_nxt;
  logic                            neg_r, neg_nxt;
  logic [PERIOD_BITS-1:0]          num_r, num_nxt;
  logic                            halt_r, halt_nxt;

  logic                            accept;
  logic                            is_nl;
  logic [7:0]                      c;
  logic                            is_digit;
  logic                            is_space;
  logic [3:0]                      dig;
  logic [NW-1:0]                   num_ext;
  logic [PERIOD_BITS-1:0]          num_acc;
  logic [lcp_pkg::KW_COUNT-1:0]    hit;
  lcp_pkg::cmd_t                   cmd;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full && !halt_r;
  assign c           = in_if.rx_byte;
  assign is_nl       = (c == lcp_pkg::CH_NL);
  assign is_digit    = (c >= lcp_pkg::CH_0) && (c <= lcp_pkg::CH_9);
  assign is_space    = ((c >= lcp_pkg::CH_TAB) && (c <= lcp_pkg::CH_CR)) ||
                       (c == lcp_pkg::CH_SPACE);
  assign dig         = 4'(c - lcp_pkg::CH_0);

  // value*10 + digit, saturating when anything spills above the period width
  assign num_ext = ({4'b0, num_r} << 3) + ({4'b0, num_r} << 1) + NW'(dig);
  assign num_acc = (num_ext[NW-1:PERIOD_BITS] != '0) ? '1 : num_ext[PERIOD_BITS-1:0];

  // line classification from the state before the newline
  always_comb begin
    for (int k = 0; k < lcp_pkg::KW_COUNT; k++) begin
      hit[k] = match_r[k] && (pos_r >= PW'(lcp_pkg::KW_LEN[k]));
    end
    cmd.celsius = 1'b0;
    if (hit[lcp_pkg::KW_SCALE]) begin
      if (scale_char_r == lcp_pkg::CH_C) begin
        cmd.status  = lcp_pkg::ST_SCALE_SET;
        cmd.celsius = 1'b1;
      end else if (scale_char_r == lcp_pkg::CH_F) begin
        cmd.status  = lcp_pkg::ST_SCALE_SET;
      end else begin
        cmd.status  = lcp_pkg::ST_SCALE_REJ;
      end
    end else if (hit[lcp_pkg::KW_PERIOD]) begin
      cmd.status = (!neg_r && (num_r != '0)) ? lcp_pkg::ST_PERIOD_SET
                                             : lcp_pkg::ST_PERIOD_REJ;
    end else if (hit[lcp_pkg::KW_STOP]) begin
      cmd.status = lcp_pkg::ST_STOP;
    end else if (hit[lcp_pkg::KW_START]) begin
      cmd.status = lcp_pkg::ST_START;
    end else if (hit[lcp_pkg::KW_LOG]) begin
      cmd.status = lcp_pkg::ST_LOG;
    end else if (hit[lcp_pkg::KW_OFF]) begin
      cmd.status = lcp_pkg::ST_OFF;
    end else begin
      cmd.status = lcp_pkg::ST_UNKNOWN;
    end
  end

  assign push        = accept && is_nl;
  assign push_cmd    = cmd;
  assign push_period = num_r;

  always_comb begin
    pos_nxt        = pos_r;
    match_nxt      = match_r;
    ended_nxt      = ended_r;
    scale_char_nxt = scale_char_r;
    phase_nxt      = phase_r;
    neg_nxt        = neg_r;
    num_nxt        = num_r;
    halt_nxt       = halt_r;
    if (accept) begin
      if (is_nl) begin
        pos_nxt        = '0;
        match_nxt      = '1;
        ended_nxt      = 1'b0;
        scale_char_nxt = '0;
        phase_nxt      = lcp_pkg::NUM_SKIP;
        neg_nxt        = 1'b0;
        num_nxt        = '0;
        halt_nxt       = (cmd.status == lcp_pkg::ST_OFF);
      end else if (!ended_r && (pos_r < PW'(LINE_CAPACITY))) begin
        if (c == lcp_pkg::CH_NUL) begin
          ended_nxt = 1'b1;
        end else begin
          for (int k = 0; k < lcp_pkg::KW_COUNT; k++) begin
            if (pos_r < PW'(lcp_pkg::KW_LEN[k])) begin
              if (c != lcp_pkg::KW_TEXT[k][pos_r[2:0]]) begin
                match_nxt[k] = 1'b0;
              end
            end else if (lcp_pkg::KW_EXACT[k]) begin
              match_nxt[k] = 1'b0;
            end
          end
          if (pos_r == PW'(lcp_pkg::SCALE_CHAR_POS)) begin
            scale_char_nxt = c;
          end
          if (pos_r >= PW'(lcp_pkg::NUMBER_POS)) begin
            case (phase_r)
              lcp_pkg::NUM_SKIP: begin
                if (c == lcp_pkg::CH_PLUS || c == lcp_pkg::CH_MINUS) begin
                  neg_nxt   = (c == lcp_pkg::CH_MINUS);
                  phase_nxt = lcp_pkg::NUM_DIGITS;
                end else if (!is_space) begin
                  if (is_digit) begin
                    num_nxt   = num_acc;
                    phase_nxt = lcp_pkg::NUM_DIGITS;
                  end else begin
                    phase_nxt = lcp_pkg::NUM_DONE;
                  end
                end
              end
              lcp_pkg::NUM_DIGITS: begin
                if (is_digit) begin
                  num_nxt = num_acc;
                end else begin
                  phase_nxt = lcp_pkg::NUM_DONE;
                end
              end
              default: begin
              end
            endcase
          end
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      match_r      <= '1;
      ended_r      <= 1'b0;
      scale_char_r <= '0;
      phase_r      <= lcp_pkg::NUM_SKIP;
      neg_r        <= 1'b0;
      num_r        <= '0;
      halt_r       <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      match_r      <= match_nxt;
      ended_r      <= ended_nxt;
      scale_char_r <= scale_char_nxt;
      phase_r      <= phase_nxt;
      neg_r        <= neg_nxt;
      num_r        <= num_nxt;
      halt_r       <= halt_nxt;
    end
  end

  // nothing leaves the front once OFF went through
  a_no_push_after_off: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> !push)
    else $error("line pushed after shut-down");

endmodule

@@ rtl/core/lcp_queue.sv @@
// ----------------------------------------------------------------------------
// lcp_queue
// Two-entry command queue between the byte front end and the back end.
// ----------------------------------------------------------------------------
module lcp_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         q_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);

  localparam int DEPTH = 2;

  logic [W-1:0] mem_r [DEPTH];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;

  assign full     = (count_r == 2'(DEPTH));
  assign q_valid  = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue underflow");

endmodule

@@ rtl/core/lcp_back.sv @@
// ----------------------------------------------------------------------------
// lcp_back
// Command back end: applies each queued command to the settings and
// presents the status report in an output register.
// ----------------------------------------------------------------------------
module lcp_back #(
  parameter int PERIOD_BITS = lcp_pkg::PERIOD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  lcp_pkg::cmd_t          q_cmd,
  input  logic [PERIOD_BITS-1:0] q_period,
  output logic                   pop,
  lcp_status_if.source           out_if
);

  localparam int OW = lcp_pkg::OUT_PERIOD_W;

  logic                   celsius_r, celsius_nxt;
  logic [PERIOD_BITS-1:0] period_r, period_nxt;
  logic                   stopped_r, stopped_nxt;
  logic                   halted_r, halted_nxt;
  logic                   out_valid_r, out_valid_nxt;
  lcp_pkg::status_t       status_r, status_nxt;
  logic [PERIOD_BITS+OW-1:0] period_ext;

  assign pop = q_valid && (!out_valid_r || out_if.ready);

  always_comb begin
    celsius_nxt   = celsius_r;
    period_nxt    = period_r;
    stopped_nxt   = stopped_r;
    halted_nxt    = halted_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (pop) begin
      out_valid_nxt = 1'b1;
      status_nxt    = q_cmd.status;
      case (q_cmd.status)
        lcp_pkg::ST_SCALE_SET:  celsius_nxt = q_cmd.celsius;
        lcp_pkg::ST_PERIOD_SET: period_nxt  = q_period;
        lcp_pkg::ST_STOP:       stopped_nxt = 1'b1;
        lcp_pkg::ST_START:      stopped_nxt = 1'b0;
        lcp_pkg::ST_OFF:        halted_nxt  = 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      celsius_r   <= 1'b0;
      period_r    <= PERIOD_BITS'(1);
      stopped_r   <= 1'b0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      celsius_r   <= celsius_nxt;
      period_r    <= period_nxt;
      stopped_r   <= stopped_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // report carries the low bits of the period, zero-extended when narrower
  assign period_ext             = {{OW{1'b0}}, period_r};
  assign out_if.valid           = out_valid_r;
  assign out_if.status          = status_r;
  assign out_if.celsius_mode    = celsius_r;
  assign out_if.report_period   = period_ext[OW-1:0];
  assign out_if.reports_stopped = stopped_r;
  assign out_if.shut_down       = halted_r;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("shut-down flag cleared");

  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    period_r != '0)
    else $error("report period became zero");

endmodule

@@ rtl/core/line_command_parser_unit.sv @@
// ----------------------------------------------------------------------------
// line_command_parser_unit
// Line command parser: matches newline-terminated command lines byte by
// byte and reports a status with the current settings at each line end.
//
//   channel   dir  payload                                     transaction
//   in_if     in   rx_byte[7:0]                                one byte
//   out_if    out  status, celsius_mode, report_period[15:0],  one line report
//                  reports_stopped, shut_down
//
// One byte is taken every cycle while the command queue is not full; the
// newline's report reaches the output register through a two-entry command
// queue. Reset is synchronous; there is no clearing pass.
// in_if.ready drops only while the queue is full, which takes a stalled
// out_if together with two more pending newlines. After OFF every byte is
// taken and dropped.
// ----------------------------------------------------------------------------
module line_command_parser_unit #(
  parameter int LINE_CAPACITY = lcp_pkg::LINE_CAPACITY_DEF,
  parameter int PERIOD_BITS   = lcp_pkg::PERIOD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  lcp_byte_if.sink     in_if,
  lcp_status_if.source out_if
);

  localparam int QW = $bits(lcp_pkg::cmd_t) + PERIOD_BITS;

  logic                   push;
  lcp_pkg::cmd_t          push_cmd;
  logic [PERIOD_BITS-1:0] push_period;
  logic                   q_full;
  logic                   q_valid;
  logic                   pop;
  logic [QW-1:0]          pop_data;
  lcp_pkg::cmd_t          q_cmd;
  logic [PERIOD_BITS-1:0] q_period;

  lcp_front #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .PERIOD_BITS   (PERIOD_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd),
    .push_period (push_period)
  );

  lcp_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_cmd, push_period}),
    .full      (q_full),
    .q_valid   (q_valid),
    .pop       (pop),
    .pop_data  (pop_data)
  );

  assign q_cmd    = lcp_pkg::cmd_t'(pop_data[QW-1:PERIOD_BITS]);
  assign q_period = pop_data[PERIOD_BITS-1:0];

  lcp_back #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_period (q_period),
    .pop      (pop),
    .out_if   (out_if)
  );

endmodule

@@ test/lcp_report_checker.sv @@
// ----------------------------------------------------------------------------
// lcp_report_checker
// Watches both channels of the line command parser. It keeps its own model
// of the incremental keyword matcher and of the settings, queues the report
// that every accepted newline should produce, and compares each report
// transaction field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module lcp_report_checker
  import lcp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  lcp_byte_if      in_ch,
  lcp_status_if    out_ch,
  output int       fail_count,
  output int       pending,
  output int       reports_checked,
  output bit [8:0] codes_seen
);

  localparam int unsigned PERIOD_MAX = (1 << PERIOD_BITS_DEF) - 1;

  typedef struct packed {
    status_t     status;
    logic        celsius;
    logic [15:0] period;
    logic        stopped;
    logic        down;
  } line_report_t;

  // state of the line being matched
  int unsigned         line_pos;
  logic [KW_COUNT-1:0] kw_alive;
  bit                  text_over;
  logic [7:0]          scale_pick;
  num_phase_t          num_phase;
  bit                  num_neg;
  int unsigned         num_mag;

  // settings kept across lines
  bit          celsius_now;
  int unsigned period_now;
  bit          stopped_now;
  bit          down_now;

  line_report_t report_q[$];
  int           errs;
  int           shown;
  int           checked;

  function automatic void restart_line();
    line_pos   = 0;
    kw_alive   = '1;
    text_over  = 1'b0;
    scale_pick = CH_NUL;
    num_phase  = NUM_SKIP;
    num_neg    = 1'b0;
    num_mag    = 0;
  endfunction

  // advances the matcher by one byte; returns 1 when a report is due
  function automatic bit parse_byte(input logic [7:0] c, output line_report_t rep);
    status_t     st;
    int unsigned d;
    int          k;
    bit          digit_turn;
    rep = '0;
    if (down_now) return 1'b0;
    if (c != CH_NL) begin
      if (text_over || line_pos >= LINE_CAPACITY_DEF) return 1'b0;
      if (c == CH_NUL) begin
        text_over = 1'b1;
        return 1'b0;
      end
      for (k = 0; k < KW_COUNT; k++) begin
        if (kw_alive[k]) begin
          if (line_pos < KW_LEN[k]) begin
            if (c != KW_TEXT[k][line_pos]) kw_alive[k] = 1'b0;
          end else if (KW_EXACT[k]) begin
            kw_alive[k] = 1'b0;
          end
        end
      end
      if (line_pos == SCALE_CHAR_POS) scale_pick = c;
      if (line_pos >= NUMBER_POS) begin
        digit_turn = 1'b1;
        if (num_phase == NUM_SKIP) begin
          if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
            digit_turn = 1'b0;
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            num_neg    = (c == CH_MINUS);
            num_phase  = NUM_DIGITS;
            digit_turn = 1'b0;
          end else begin
            num_phase = NUM_DIGITS;
          end
        end
        if (digit_turn && num_phase == NUM_DIGITS) begin
          if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            if (num_mag > (PERIOD_MAX - d) / 10) num_mag = PERIOD_MAX;
            else num_mag = num_mag * 10 + d;
          end else begin
            num_phase = NUM_DONE;
          end
        end
      end
      line_pos++;
      return 1'b0;
    end
    // newline: keywords are tried in order of precedence
    if (kw_alive[KW_SCALE] && line_pos >= KW_LEN[KW_SCALE]) begin
      if (scale_pick == CH_C) begin
        celsius_now = 1'b1;
        st = ST_SCALE_SET;
      end else if (scale_pick == CH_F) begin
        celsius_now = 1'b0;
        st = ST_SCALE_SET;
      end else begin
        st = ST_SCALE_REJ;
      end
    end else if (kw_alive[KW_PERIOD] && line_pos >= KW_LEN[KW_PERIOD]) begin
      if (!num_neg && num_mag > 0) begin
        period_now = num_mag;
        st = ST_PERIOD_SET;
      end else begin
        st = ST_PERIOD_REJ;
      end
    end else if (kw_alive[KW_STOP] && line_pos >= KW_LEN[KW_STOP]) begin
      stopped_now = 1'b1;
      st = ST_STOP;
    end else if (kw_alive[KW_START] && line_pos >= KW_LEN[KW_START]) begin
      stopped_now = 1'b0;
      st = ST_START;
    end else if (kw_alive[KW_LOG] && line_pos >= KW_LEN[KW_LOG]) begin
      st = ST_LOG;
    end else if (kw_alive[KW_OFF] && line_pos >= KW_LEN[KW_OFF]) begin
      down_now = 1'b1;
      st = ST_OFF;
    end else begin
      st = ST_UNKNOWN;
    end
    restart_line();
    rep = '{status: st, celsius: celsius_now, period: 16'(period_now),
            stopped: stopped_now, down: down_now};
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    line_report_t want;
    line_report_t got;
    if (!rst_n) begin
      restart_line();
      celsius_now = 1'b0;
      period_now  = 1;
      stopped_now = 1'b0;
      down_now    = 1'b0;
      report_q.delete();
      errs    = 0;
      shown   = 0;
      checked = 0;
      codes_seen <= '0;
    end else begin
      // compare first so a report with nothing queued is caught
      if (out_ch.valid && out_ch.ready) begin
        got = '{status: status_t'(out_ch.status), celsius: out_ch.celsius_mode,
                period: out_ch.report_period, stopped: out_ch.reports_stopped,
                down: out_ch.shut_down};
        checked++;
        if (report_q.size() == 0) begin
          errs++;
          if (shown < 10) begin
            shown++;
            $display("unexpected report: status %0d celsius %0b period %0d stopped %0b down %0b",
                     got.status, got.celsius, got.period, got.stopped, got.down);
          end
        end else begin
          want = report_q.pop_front();
          codes_seen[want.status] <= 1'b1;
          if (got !== want) begin
            errs++;
            if (shown < 10) begin
              shown++;
              $display("report mismatch: expected status %0d celsius %0b period %0d",
                       want.status, want.celsius, want.period,
                       " stopped %0b down %0b", want.stopped, want.down);
              $display("                 got      status %0d celsius %0b period %0d",
                       got.status, got.celsius, got.period,
                       " stopped %0b down %0b", got.stopped, got.down);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (parse_byte(in_ch.rx_byte, want)) report_q.push_back(want);
      end
    end
    fail_count      <= errs;
    pending         <= report_q.size();
    reports_checked <= checked;
  end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Top of the line command parser bench. Sends directed command lines
// (every keyword, near misses, NUL bytes, the line capacity boundary) and
// then random, mostly well-formed lines with bursts of idling on both
// channels and one long output stall; the checker judges every report.
// ----------------------------------------------------------------------------
module tb;
  import lcp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int LIMIT        = 500000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 650;
  localparam int CALM_FROM    = 550;
  localparam int PRESS_AT     = 300;

  logic clk = 1'b0;
  logic rst_n;

  lcp_byte_if   in_ch ();
  lcp_status_if out_ch ();

  int       fail_count;
  int       pending;
  int       reports_checked;
  bit [8:0] codes_seen;

  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int tx_odds  = 2;
  int rx_odds  = 2;
  int bytes_sent;
  int random_bytes;
  int cycle_count;

  string kw_words [KW_COUNT] = '{"SCALE=", "PERIOD=", "STOP", "START", "LOG", "OFF"};

  line_command_parser_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  lcp_report_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .pending         (pending),
    .reports_checked (reports_checked),
    .codes_seen      (codes_seen)
  );

  always #5 clk = ~clk;

  function automatic byte_q_t text_of(string s);
    byte_q_t q;
    int i;
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // any byte except the newline
  function automatic logic [7:0] any_text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    if (b >= CH_NL) b = b + 8'd1;
    return b;
  endfunction

  function automatic byte_q_t compose_command();
    byte_q_t q;
    int kind;
    int n;
    int r;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      q = text_of("SCALE=");
      case ($urandom_range(0, 3))
        0: q.push_back(CH_C);
        1: q.push_back(CH_F);
        2: q.push_back(any_text_byte());
        default: ;
      endcase
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) q.push_back(any_text_byte());
    end else if (kind < 40) begin
      q = text_of("PERIOD=");
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 4))
            0: q.push_back(CH_SPACE);
            1: q.push_back(CH_TAB);
            2: q.push_back(8'h0B);
            3: q.push_back(8'h0C);
            default: q.push_back(CH_CR);
          endcase
        end
      end
      r = $urandom_range(0, 9);
      if (r == 0) q.push_back(CH_MINUS);
      else if (r == 1) q.push_back(CH_PLUS);
      r = $urandom_range(0, 9);
      if (r == 0) n = 0;
      else if (r < 7) n = $urandom_range(1, 3);
      else n = $urandom_range(4, 7);
      repeat (n) q.push_back(8'(CH_0 + $urandom_range(0, 9)));
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) q.push_back(any_text_byte());
    end else if (kind < 50) begin
      q = text_of(kind < 45 ? "STOP" : "START");
      if ($urandom_range(0, 4) < 2) q.push_back(any_text_byte());
    end else if (kind < 58) begin
      q = text_of("LOG");
      repeat ($urandom_range(0, 6)) q.push_back(any_text_byte());
    end else if (kind < 68) begin
      // near miss on some keyword
      q = text_of(kw_words[$urandom_range(0, KW_COUNT - 1)]);
      if ($urandom_range(0, 1) == 0) begin
        n = $urandom_range(0, q.size() - 1);
        while (q.size() > n) q.pop_back();
      end else begin
        q[$urandom_range(0, q.size() - 1)] = any_text_byte();
      end
      if ($urandom_range(0, 2) == 0) q.push_back(any_text_byte());
    end else if (kind >= 73) begin
      repeat ($urandom_range(1, 12)) q.push_back(any_text_byte());
    end
    if ($urandom_range(0, 11) == 0) q.insert($urandom_range(0, q.size()), CH_NUL);
    // keep the block alive: a line whose text is exactly OFF gets spoiled
    n = 0;
    while (n < q.size() && q[n] != CH_NUL) n++;
    if (n == 3 && q[0] == KW_TEXT[KW_OFF][0] && q[1] == KW_TEXT[KW_OFF][1] &&
        q[2] == KW_TEXT[KW_OFF][2]) q[0] = 8'h6F;
    return q;
  endfunction

  task automatic offer_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 15) < tx_odds) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_line_bytes(input byte_q_t q);
    foreach (q[i]) offer_byte(q[i]);
    offer_byte(CH_NL);
  endtask

  task automatic send_text(input string s);
    send_line_bytes(text_of(s));
  endtask

  // cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d reports outstanding", cycle_count, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // report receiver
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_odds = $urandom_range(0, 5);
      if (hold_req) begin
        // long hold-off so the command queue fills and the input stalls
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 15) < rx_odds) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // stimulus
  initial begin
    byte_q_t q;
    bit pressed;
    pressed       = 1'b0;
    bytes_sent    = 0;
    random_bytes  = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_text("SCALE=C");
    send_text("SCALE=F");
    send_text("SCALE=");
    send_text("SCALE=X");
    send_text("SCALE=Cxyz");
    send_text("SCALE=c");
    send_text("SCALE=F");
    send_text("PERIOD=60");
    send_text("PERIOD=0");
    send_text("PERIOD=-5");
    send_text("PERIOD=+-3");
    send_text("PERIOD=");
    q = text_of("PERIOD=");
    q = {q, CH_TAB, 8'h0B, 8'h0C, CH_CR, CH_SPACE, CH_PLUS, text_of("7x9")};
    send_line_bytes(q);
    send_text("PERIOD=99999");
    send_text("PERIOD=65536");
    send_text("PERIOD=1");
    send_text("PERIOD=65535");
    send_text("STOP");
    send_text("STOPX");
    send_text("START");
    send_text("STARTS");
    send_text("STAR");
    send_text("STOP");
    send_text("LOG");
    send_text("LOGGING");
    send_text("LO");
    send_text("");
    send_text("OFFX");
    send_text("OF");
    // NUL ends the text: first unrecognized, then a plain stop
    q = text_of("ST");
    q = {q, CH_NUL, text_of("OP")};
    send_line_bytes(q);
    q = text_of("STOP");
    q = {q, CH_NUL, text_of("X")};
    send_line_bytes(q);
    q = text_of("SCALE=");
    q = {q, CH_NUL, CH_C};
    send_line_bytes(q);
    q = '{CH_NUL};
    send_line_bytes(q);
    q = '{8'hFF, 8'h80, 8'h7F, 8'h01};
    send_line_bytes(q);
    // capacity boundary: last kept digit, then first dropped digit
    q = text_of("PERIOD=");
    repeat (LINE_CAPACITY_DEF - 8) q.push_back(CH_SPACE);
    q.push_back(8'(CH_0 + 5));
    q.push_back(8'(CH_0 + 7));
    send_line_bytes(q);
    send_text("START");

    while (random_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) tx_odds = $urandom_range(0, 4);
      if (random_bytes >= CALM_FROM) calm = 1'b1;
      if (!pressed && random_bytes >= PRESS_AT) begin
        pressed  = 1'b1;
        hold_req = 1'b1;
        while (hold_req) send_text($urandom_range(0, 1) ? "" : "STOP");
      end
      q = compose_command();
      send_line_bytes(q);
      random_bytes += q.size() + 1;
    end

    // shut down; everything after must be swallowed
    send_text("OFF");
    send_text("START");
    send_text("SCALE=C");
    repeat (8) offer_byte(any_text_byte());
    offer_byte(CH_NL);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("sent %0d bytes (%0d in random lines), checked %0d line reports",
             bytes_sent, random_bytes, reports_checked);
    $display("status codes reported (bit n = code n): %b, output held off %0d cycles once",
             codes_seen, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
